### design/vacuum_valve_deadband_regulator_defines.svh
// ----------------------------------------------------------------------------
// Vacuum valve regulator assertion macros
// Shared concurrent check wrappers used by the regulator RTL files.
// ----------------------------------------------------------------------------
`ifndef VACUUM_VALVE_DEADBAND_REGULATOR_DEFINES_SVH
`define VACUUM_VALVE_DEADBAND_REGULATOR_DEFINES_SVH

// Clocked check, switched off while reset is held
`define VVDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that must also hold during reset
`define VVDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/vvdr_pkg.sv
// ----------------------------------------------------------------------------
// Vacuum valve regulator package
// Shared constants, payload structs and internal types.
// ----------------------------------------------------------------------------
package vvdr_pkg;

    // Number of suction points (1..32)
    localparam int CHANNELS   = 2;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAME_CH_W = 5;

    localparam int TARGET_W = 12;
    localparam int SAMPLE_W = 12;
    localparam int BAND_W   = 6;

    // Sample scaling: mag = (sample * 35200 + 3685) / 7371
    localparam int X_W         = 28;
    localparam int Q_W         = 15;
    localparam int PROD_W      = X_W + 16;
    localparam int RECIP_SHIFT = 28;

    localparam logic [7:0]            FRAME_END     = 8'hFF;
    localparam logic [FRAME_CH_W:0]   CHAN_LIMIT    = (FRAME_CH_W + 1)'(CHANNELS);
    localparam logic [15:0]           SCALE_NUM     = 16'd35200;
    localparam logic [11:0]           SCALE_RND     = 12'd3685;
    localparam logic [12:0]           SCALE_DEN     = 13'd7371;
    // floor(2^28 / 7371); estimate is low by at most one
    localparam logic [15:0]           SCALE_RECIP   = 16'd36417;
    localparam logic [BAND_W-1:0]     BAND_RESET    = 6'd1;

    typedef logic [CH_W-1:0]          idx_t;
    typedef logic [FRAME_CH_W:0]      fch_t;
    typedef logic [TARGET_W-1:0]      target_t;
    typedef logic [10:0]              mag_t;
    typedef logic [X_W-1:0]           x_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic [Q_W:0]             qx_t;
    typedef logic signed [15:0]       press_t;
    typedef logic signed [16:0]       cmp_t;

    typedef enum logic {
        MODE_LINK   = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_SUCK = 2'd1,
        ACT_STOP = 2'd2,
        ACT_VENT = 2'd3
    } action_t;

    // Input item
    typedef struct packed {
        logic                mode;
        logic [7:0]          link_byte;
        logic                channel;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    // Result item
    typedef struct packed {
        logic               drive_channel;
        logic               suction_pin;
        logic               release_pin;
        logic signed [15:0] pressure_q4;
        action_t            action;
    } result_t;

    // One channel's stored state
    typedef struct packed {
        logic    regulating;
        target_t target;
    } entry_t;

    // Operation carried down the pipeline
    typedef struct packed {
        logic    is_frame;
        idx_t    idx;
        target_t neg_target;
    } op_t;

endpackage

### design/vvdr_state_ram.sv
// ----------------------------------------------------------------------------
// Channel state memory
// One-write one-read synchronous RAM with registered, write-through read
// data. Entries never written read as zero.
// ----------------------------------------------------------------------------
`include "vacuum_valve_deadband_regulator_defines.svh"

module vvdr_state_ram (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             re,
    input  vvdr_pkg::idx_t   raddr,
    output vvdr_pkg::entry_t rdata,
    input  logic             we,
    input  vvdr_pkg::idx_t   waddr,
    input  vvdr_pkg::entry_t wdata
);

    vvdr_pkg::entry_t                mem [vvdr_pkg::CHANNELS];
    vvdr_pkg::entry_t                rd_reg;
    logic                            rd_ok_reg;
    logic [vvdr_pkg::CHANNELS-1:0]   written_reg;
    logic                            bypass;

    // Same-cycle write to the read address wins
    assign bypass = we && (waddr == raddr);

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= bypass ? wdata : mem[raddr];
        end
    end

    // Written flags stand in for the cleared reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                written_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_ok_reg <= bypass || written_reg[raddr];
            end
        end
    end

    assign rdata = rd_ok_reg ? rd_reg : '0;

    `VVDR_ASSERT(a_ram_bypass, $past(re && we && (raddr == waddr)) |-> (rdata == $past(wdata)), "read did not return same-cycle write")

endmodule

### design/vvdr_link_decode.sv
// ----------------------------------------------------------------------------
// Link byte history and frame decode
// Keeps the two-byte history and turns an accepted item into a pipeline
// operation, or flags it as one that changes no channel state.
// ----------------------------------------------------------------------------
module vvdr_link_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  vvdr_pkg::item_t item,
    output logic            op_ok,
    output vvdr_pkg::op_t   op
);

    logic [7:0]         newer_reg;
    logic [7:0]         older_reg;
    logic [7:0]         newer_next;
    logic [7:0]         older_next;
    logic               is_link;
    logic               is_end;
    vvdr_pkg::fch_t     frame_ch;
    vvdr_pkg::fch_t     sample_ch;
    vvdr_pkg::mag_t     mag;

    // Frame decode from the current history
    always_comb
    begin
        is_link   = (item.mode == vvdr_pkg::MODE_LINK);
        is_end    = (item.link_byte == vvdr_pkg::FRAME_END);
        frame_ch  = vvdr_pkg::fch_t'(newer_reg[7:3]);
        sample_ch = vvdr_pkg::fch_t'(item.channel);
        mag       = vvdr_pkg::mag_t'({newer_reg[2:0], 7'b0}) + vvdr_pkg::mag_t'(older_reg);

        op.is_frame   = is_link;
        op.neg_target = vvdr_pkg::target_t'(0) - vvdr_pkg::target_t'(mag);
        op.idx        = is_link ? frame_ch[vvdr_pkg::CH_W-1:0]
                                : sample_ch[vvdr_pkg::CH_W-1:0];

        // Plain link bytes and out-of-range channels never enter the pipe
        if (is_link)
        begin
            op_ok = is_end && (frame_ch < vvdr_pkg::CHAN_LIMIT);
        end
        else
        begin
            op_ok = (sample_ch < vvdr_pkg::CHAN_LIMIT);
        end
    end

    // History shift; the end byte is not stored
    always_comb
    begin
        newer_next = newer_reg;
        older_next = older_reg;
        if (take && is_link && !is_end)
        begin
            older_next = newer_reg;
            newer_next = item.link_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newer_reg <= '0;
            older_reg <= '0;
        end
        else
        begin
            newer_reg <= newer_next;
            older_reg <= older_next;
        end
    end

endmodule

### design/vvdr_scale_pipe.sv
// ----------------------------------------------------------------------------
// Pressure scaling pipeline
// Four stages: scale the sample, multiply by the reciprocal of 7371,
// back-multiply, then correct the quotient and negate. Operations ride along.
// ----------------------------------------------------------------------------
`include "vacuum_valve_deadband_regulator_defines.svh"

module vvdr_scale_pipe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  vvdr_pkg::op_t                    in_op,
    input  logic [vvdr_pkg::SAMPLE_W-1:0]    in_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vvdr_pkg::op_t                    out_op,
    output vvdr_pkg::press_t                 out_pressure
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    vvdr_pkg::op_t      op1_reg, op2_reg, op3_reg, op4_reg;
    vvdr_pkg::x_t       x1_reg, x2_reg, x3_reg, m3_reg;
    logic [vvdr_pkg::Q_W-1:0] q2_reg, q3_reg;
    vvdr_pkg::press_t   p4_reg;

    vvdr_pkg::x_t       x1_next;
    vvdr_pkg::prod_t    prod2;
    logic [vvdr_pkg::Q_W-1:0] q2_next;
    vvdr_pkg::x_t       m3_next;
    vvdr_pkg::x_t       rem4;
    vvdr_pkg::qx_t      mag4;
    vvdr_pkg::press_t   p4_next;

    // Stage advance: a stage takes new data when empty or moving on
    always_comb
    begin
        r4 = !v4_reg || out_ready;
        r3 = !v3_reg || r4;
        r2 = !v2_reg || r3;
        r1 = !v1_reg || r2;
    end

    assign in_ready = r1;

    // Datapath arithmetic, at most one multiply per stage
    always_comb
    begin
        x1_next = vvdr_pkg::x_t'(in_sample) * vvdr_pkg::x_t'(vvdr_pkg::SCALE_NUM)
                  + vvdr_pkg::x_t'(vvdr_pkg::SCALE_RND);
        prod2   = vvdr_pkg::prod_t'(x1_reg) * vvdr_pkg::prod_t'(vvdr_pkg::SCALE_RECIP);
        q2_next = prod2[vvdr_pkg::RECIP_SHIFT +: vvdr_pkg::Q_W];
        m3_next = vvdr_pkg::x_t'(q2_reg) * vvdr_pkg::x_t'(vvdr_pkg::SCALE_DEN);
        rem4    = x3_reg - m3_reg;
        // Estimate is low by at most one
        mag4    = (rem4 >= vvdr_pkg::x_t'(vvdr_pkg::SCALE_DEN))
                  ? vvdr_pkg::qx_t'(q3_reg) + 1'b1 : vvdr_pkg::qx_t'(q3_reg);
        p4_next = -$signed(mag4);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            op1_reg <= in_op;
            x1_reg  <= x1_next;
        end
        if (r2)
        begin
            op2_reg <= op1_reg;
            x2_reg  <= x1_reg;
            q2_reg  <= q2_next;
        end
        if (r3)
        begin
            op3_reg <= op2_reg;
            x3_reg  <= x2_reg;
            q3_reg  <= q2_reg;
            m3_reg  <= m3_next;
        end
        if (r4)
        begin
            op4_reg <= op3_reg;
            p4_reg  <= p4_next;
        end
    end

    assign out_valid    = v4_reg;
    assign out_op       = op4_reg;
    assign out_pressure = p4_reg;

    `VVDR_ASSERT(a_quot_estimate, v3_reg |-> (x3_reg >= m3_reg) && ((x3_reg - m3_reg) < vvdr_pkg::x_t'(2 * vvdr_pkg::SCALE_DEN)), "reciprocal quotient estimate off by more than one")

endmodule

### design/vacuum_valve_deadband_regulator.sv
// ----------------------------------------------------------------------------
// Vacuum valve dead-band regulator, top level
// Link decode, pressure scaling pipe, state RAM read-modify-write and the
// result register.
// ----------------------------------------------------------------------------
// Takes one item per clock unless result_ready back-pressure stalls the pipe;
// an accepted sample reaches the output register through four scaling stages
// (sample scale, reciprocal multiply, back-multiply, quotient correction),
// then the decide stage, whose per-channel state RAM read is issued as the
// operation enters it and which writes the state back, then the result
// register. The RAM read is registered and bypasses a write to the
// same channel in the same cycle, so back-to-back items on one channel see
// each other's updates. Link bytes, frames and samples for channels at or
// above CHANNELS give no result; every other sample gives exactly one.
// Stored targets and regulating flags reset to zero through per-channel
// written flags, so no clearing pass is needed after reset. band_reg is
// written through cfg_we/cfg_wdata and resets to 1.
// ----------------------------------------------------------------------------
`include "vacuum_valve_deadband_regulator_defines.svh"

module vacuum_valve_deadband_regulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  vvdr_pkg::item_t                item_data,
    output logic                           result_valid,
    input  logic                           result_ready,
    output vvdr_pkg::result_t              result_data,
    input  logic                           cfg_we,
    input  logic [vvdr_pkg::BAND_W-1:0]    cfg_wdata
);

    logic                          take;
    logic                          op_ok;
    vvdr_pkg::op_t                 op_in;

    logic                          v4;
    vvdr_pkg::op_t                 op4;
    vvdr_pkg::press_t              p4;

    logic                          v5_reg;
    vvdr_pkg::op_t                 op5_reg;
    vvdr_pkg::press_t              p5_reg;
    logic                          r5;
    logic                          s5_go;
    logic                          out_free;
    logic                          out_load;

    logic [vvdr_pkg::BAND_W-1:0]   band_reg;
    logic [vvdr_pkg::BAND_W-1:0]   band_next;

    vvdr_pkg::entry_t              ent;
    logic                          wr_en;
    vvdr_pkg::entry_t              wr_data;

    vvdr_pkg::cmp_t                tgt_s;
    vvdr_pkg::cmp_t                band_s;
    vvdr_pkg::cmp_t                hi;
    vvdr_pkg::cmp_t                lo;
    vvdr_pkg::cmp_t                p_s;
    logic                          stop;

    logic                          result_valid_reg;
    logic                          result_valid_next;
    vvdr_pkg::result_t             result_reg;
    vvdr_pkg::result_t             result_next;

    assign take = item_valid && item_ready;

    // Band register
    assign band_next = cfg_we ? cfg_wdata : band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= vvdr_pkg::BAND_RESET;
        end
        else
        begin
            band_reg <= band_next;
        end
    end

    // Link history and operation decode
    vvdr_link_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item_data),
        .op_ok (op_ok),
        .op    (op_in)
    );

    // Pressure scaling
    vvdr_scale_pipe u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (take && op_ok),
        .in_ready     (item_ready),
        .in_op        (op_in),
        .in_sample    (item_data.sample),
        .out_valid    (v4),
        .out_ready    (r5),
        .out_op       (op4),
        .out_pressure (p4)
    );

    // Channel state, read as an operation moves into the decide stage
    vvdr_state_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (v4 && r5),
        .raddr (op4.idx),
        .rdata (ent),
        .we    (wr_en),
        .waddr (op5_reg.idx),
        .wdata (wr_data)
    );

    // Decide stage handshake
    always_comb
    begin
        out_free = !result_valid_reg || result_ready;
        s5_go    = v5_reg && (op5_reg.is_frame || out_free);
        r5       = !v5_reg || s5_go;
        out_load = s5_go && !op5_reg.is_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (r5)
        begin
            v5_reg <= v4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r5)
        begin
            op5_reg <= op4;
            p5_reg  <= p4;
        end
    end

    // Band limits in Q4
    always_comb
    begin
        tgt_s  = vvdr_pkg::cmp_t'(signed'(ent.target));
        band_s = vvdr_pkg::cmp_t'({1'b0, band_reg});
        hi     = (tgt_s + band_s) <<< 4;
        lo     = (tgt_s - band_s) <<< 4;
        p_s    = vvdr_pkg::cmp_t'(p5_reg);
    end

    // Valve decision and state write-back
    always_comb
    begin
        stop                      = 1'b0;
        result_next.drive_channel = op5_reg.idx[0];
        result_next.pressure_q4   = p5_reg;
        result_next.suction_pin   = 1'b1;
        result_next.release_pin   = 1'b0;
        result_next.action        = vvdr_pkg::ACT_HOLD;

        if (!ent.regulating)
        begin
            result_next.action = vvdr_pkg::ACT_HOLD;
        end
        else if (p_s >= hi)
        begin
            result_next.suction_pin = 1'b0;
            result_next.action      = vvdr_pkg::ACT_SUCK;
        end
        else if (p_s >= lo)
        begin
            result_next.action = vvdr_pkg::ACT_STOP;
            stop               = 1'b1;
        end
        else
        begin
            result_next.release_pin = 1'b1;
            result_next.action      = vvdr_pkg::ACT_VENT;
        end

        // A frame arms its channel only on a changed target
        if (op5_reg.is_frame)
        begin
            wr_data.regulating = 1'b1;
            wr_data.target     = op5_reg.neg_target;
            wr_en              = s5_go && (ent.target != op5_reg.neg_target);
        end
        else
        begin
            wr_data.regulating = 1'b0;
            wr_data.target     = ent.target;
            wr_en              = s5_go && stop;
        end
    end

    // Result register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `VVDR_ASSERT(a_stop_clears, (out_load && (result_next.action == vvdr_pkg::ACT_STOP)) |-> (wr_en && !wr_data.regulating), "stop result without clearing the channel")
    `VVDR_ASSERT(a_load_shows, out_load |=> (result_valid && (result_data.pressure_q4 == $past(p5_reg))), "loaded result not presented")
    `VVDR_ASSERT_ALWAYS(a_frame_no_write_idle, (!v5_reg) |-> !wr_en, "state write with empty decide stage")

endmodule
